// ===== design/psm_pkg.sv =====
// Package for the profile slope smoother: payload structs, divider result
// struct, field widths and configuration register indexes. No dependencies.
package psm_pkg;

    // Field widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int WIN_W        = 5;
    localparam int MAXS_W       = 15;
    localparam int CNT_W        = 5;
    localparam int SUM_WIDTH    = SAMPLE_WIDTH + CNT_W;
    localparam int PEND_W       = 5;
    localparam int SEEN_W       = 6;
    localparam int HIST_DEPTH   = 32;
    localparam int HIST_AW      = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // Window limits
    localparam int MAX_WINDOW = 31;
    localparam logic [WIN_W-1:0] MAX_WIN_EFF = WIN_W'(MAX_WINDOW);

    // Saturation limits
    localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(HIST_DEPTH - 1);
    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLOPE   = CFG_IDX_W'(1);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] slope_sample;
        logic                           last_sample;
    } psm_in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] smoothed_slope;
        logic                           last_result;
    } psm_out_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic                 done;
        logic                 neg;
        logic [SUM_WIDTH-1:0] quo;
    } psm_div_res_t;

endpackage

// ===== design/psm_div.sv =====
// Bit-serial restoring divider: signed window sum by sample count, one
// quotient bit per cycle, truncating toward zero. Depends on psm_pkg.
module psm_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [psm_pkg::SUM_WIDTH-1:0] dividend,
    input  logic [psm_pkg::CNT_W-1:0]           divisor,
    output psm_pkg::psm_div_res_t               res
);

    localparam int STEP_W = $clog2(psm_pkg::SUM_WIDTH + 1);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [STEP_W-1:0]              step_reg, step_next;
    logic [psm_pkg::CNT_W-1:0]      rem_reg, rem_next;
    logic [psm_pkg::SUM_WIDTH-1:0]  quo_reg, quo_next;
    logic                           neg_reg, neg_next;
    logic [psm_pkg::CNT_W-1:0]      dvs_reg, dvs_next;

    logic [psm_pkg::CNT_W:0]        shifted;
    logic [psm_pkg::CNT_W:0]        diff;
    logic                           ge;
    logic [psm_pkg::SUM_WIDTH-1:0]  mag;

    // Shift in one dividend bit and try the subtraction
    assign shifted = {rem_reg, quo_reg[psm_pkg::SUM_WIDTH-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});
    assign mag     = dividend[psm_pkg::SUM_WIDTH-1] ? (~dividend + 1'b1) : dividend;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            // load magnitude and sign
            busy_next = 1'b1;
            step_next = STEP_W'(psm_pkg::SUM_WIDTH);
            rem_next  = '0;
            quo_next  = mag;
            neg_next  = dividend[psm_pkg::SUM_WIDTH-1];
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // advance one quotient bit
            rem_next  = ge ? diff[psm_pkg::CNT_W-1:0] : shifted[psm_pkg::CNT_W-1:0];
            quo_next  = {quo_reg[psm_pkg::SUM_WIDTH-2:0], ge};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        dvs_reg <= dvs_next;
    end

    assign res.done = done_reg;
    assign res.neg  = neg_reg;
    assign res.quo  = quo_reg;

endmodule

// ===== design/profile_slope_smoother.sv =====
// Profile slope smoother: centered moving average with edge shrink and clamp.
// A result's window holds cnt (1..31) samples; the sum reads the history
// memory one sample a cycle and the divider yields one quotient bit a cycle.
// A new input request is taken only in idle, after the results it completes.
// Reset (synchronous, active low) clears control state; history needs no clear.
module profile_slope_smoother (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  psm_pkg::psm_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output psm_pkg::psm_out_t                   m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [psm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_CHECK   = 7'b0000010,
        ST_SUM     = 7'b0000100,
        ST_SUMWAIT = 7'b0001000,
        ST_LOAD    = 7'b0010000,
        ST_DIV     = 7'b0100000,
        ST_EMIT    = 7'b1000000
    } psm_state_t;

    psm_state_t                         state_reg, state_next;
    logic [psm_pkg::WIN_W-1:0]          win_reg;
    logic [psm_pkg::MAXS_W-1:0]         max_reg;
    logic [psm_pkg::HIST_AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [psm_pkg::SEEN_W-1:0]         seen_reg, seen_next;
    logic [psm_pkg::PEND_W-1:0]         pend_reg, pend_next;
    logic                               last_reg, last_next;
    logic [psm_pkg::HIST_AW-1:0]        off_reg, off_next;
    logic [psm_pkg::HIST_AW-1:0]        hi_reg, hi_next;
    logic [psm_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [psm_pkg::SUM_WIDTH-1:0] sum_reg, sum_next;
    logic                               rd_valid_reg;
    logic [psm_pkg::SAMPLE_WIDTH-1:0]   rd_data_reg;
    logic                               m_valid_reg, m_valid_next;
    psm_pkg::psm_out_t                  m_data_reg, m_data_next;

    logic [psm_pkg::SAMPLE_WIDTH-1:0]   hist_mem [psm_pkg::HIST_DEPTH];

    logic                               s_take;
    logic [psm_pkg::WIN_W-1:0]          w_eff;
    logic [psm_pkg::WIN_W-1:0]          half;
    logic [psm_pkg::WIN_W-1:0]          right;
    logic                               more;
    logic [psm_pkg::PEND_W-1:0]         d;
    logic signed [psm_pkg::PEND_W+1:0]  lo_s;
    logic [psm_pkg::HIST_AW-1:0]        lo_c;
    logic [psm_pkg::PEND_W:0]           hi_raw;
    logic [psm_pkg::SEEN_W-1:0]         seen_m1;
    logic [psm_pkg::HIST_AW-1:0]        lim;
    logic [psm_pkg::HIST_AW-1:0]        hi_c;
    logic [psm_pkg::HIST_AW-1:0]        rd_addr;
    logic                               div_start;
    psm_pkg::psm_div_res_t              div_res;
    logic [psm_pkg::MAXS_W-1:0]         mag_c;
    logic [psm_pkg::SAMPLE_WIDTH-1:0]   mag_ext;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Effective window, half width and right reach
    always_comb begin
        if (win_reg == '0) begin
            w_eff = psm_pkg::WIN_W'(1);
        end else if (win_reg > psm_pkg::MAX_WIN_EFF) begin
            w_eff = psm_pkg::MAX_WIN_EFF;
        end else begin
            w_eff = win_reg;
        end
    end
    assign half  = w_eff >> 1;
    assign right = w_eff - half - 1'b1;

    // Window bounds of the oldest unanswered position, cut at the profile edges
    assign more    = (pend_reg != '0) && (last_reg || (pend_reg > right));
    assign d       = pend_reg - 1'b1;
    assign lo_s    = $signed({2'b00, d}) - $signed({2'b00, right});
    assign lo_c    = lo_s[psm_pkg::PEND_W+1] ? '0 : lo_s[psm_pkg::HIST_AW-1:0];
    assign hi_raw  = {1'b0, d} + {1'b0, half};
    assign seen_m1 = seen_reg - 1'b1;
    assign lim     = (seen_m1 > psm_pkg::SEEN_W'(psm_pkg::HIST_DEPTH - 1))
                   ? psm_pkg::HIST_AW'(psm_pkg::HIST_DEPTH - 1)
                   : seen_m1[psm_pkg::HIST_AW-1:0];
    assign hi_c    = (hi_raw > {1'b0, lim}) ? lim : hi_raw[psm_pkg::HIST_AW-1:0];

    // Newest sample sits just behind the write pointer
    assign rd_addr   = wr_ptr_reg - 1'b1 - off_reg;
    assign div_start = (state_reg == ST_LOAD);

    // Clamp the quotient magnitude and restore the sign
    assign mag_c   = (div_res.quo > psm_pkg::SUM_WIDTH'(max_reg))
                   ? max_reg : div_res.quo[psm_pkg::MAXS_W-1:0];
    assign mag_ext = {1'b0, mag_c};

    psm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .res      (div_res)
    );

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        wr_ptr_next  = wr_ptr_reg;
        seen_next    = seen_reg;
        pend_next    = pend_reg;
        last_next    = last_reg;
        off_next     = off_reg;
        hi_next      = hi_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // accumulate returning history reads
        if (rd_valid_reg) begin
            sum_next = sum_reg + {{(psm_pkg::SUM_WIDTH - psm_pkg::SAMPLE_WIDTH)
                                   {rd_data_reg[psm_pkg::SAMPLE_WIDTH-1]}}, rd_data_reg};
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                    seen_next   = (seen_reg == psm_pkg::SEEN_MAX) ? seen_reg
                                                                  : seen_reg + 1'b1;
                    pend_next   = (pend_reg == psm_pkg::PEND_MAX) ? pend_reg
                                                                  : pend_reg + 1'b1;
                    last_next   = s_data.last_sample;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (more) begin
                    off_next   = lo_c;
                    hi_next    = hi_c;
                    cnt_next   = hi_c - lo_c + 1'b1;
                    sum_next   = '0;
                    state_next = ST_SUM;
                end else begin
                    if (last_reg) begin
                        seen_next = '0;
                        pend_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SUM: begin
                off_next = off_reg + 1'b1;
                if (off_reg == hi_reg) begin
                    state_next = ST_SUMWAIT;
                end
            end
            ST_SUMWAIT: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_res.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.smoothed_slope = div_res.neg ? -mag_ext : mag_ext;
                    m_data_next.last_result    = last_reg && (pend_reg == psm_pkg::PEND_W'(1));
                    pend_next    = pend_reg - 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wr_ptr_reg   <= '0;
            seen_reg     <= '0;
            pend_reg     <= '0;
            last_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wr_ptr_reg   <= wr_ptr_next;
            seen_reg     <= seen_next;
            pend_reg     <= pend_next;
            last_reg     <= last_next;
            rd_valid_reg <= (state_reg == ST_SUM);
            m_valid_reg  <= m_valid_next;
        end
        off_reg    <= off_next;
        hi_reg     <= hi_next;
        cnt_reg    <= cnt_next;
        sum_reg    <= sum_next;
        m_data_reg <= m_data_next;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= psm_pkg::WIN_W'(3);
            max_reg <= '1;
        end else if (cfg_valid && cfg_ready) begin
            priority if (cfg_index == psm_pkg::CFG_WINDOW_SIZE) begin
                win_reg <= cfg_data[psm_pkg::WIN_W-1:0];
            end else if (cfg_index == psm_pkg::CFG_MAX_SLOPE) begin
                max_reg <= cfg_data[psm_pkg::MAXS_W-1:0];
            end else begin
                win_reg <= win_reg;
            end
        end
    end

    // History memory: write on request, registered read
    always_ff @(posedge aclk) begin
        if (s_take) begin
            hist_mem[wr_ptr_reg] <= s_data.slope_sample;
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    // Assertions
    a_sum_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM) |-> (off_reg <= hi_reg && cnt_reg != '0))
        else $error("window read beyond its upper bound");

    a_last_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && last_reg) |-> (pend_reg == '0 && seen_reg == '0))
        else $error("profile not flushed after its last sample");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_emit_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (pend_reg != '0 && pend_reg <= seen_reg))
        else $error("result emitted with no pending position");

endmodule

// ===== tb/slope_smoother_checker.sv =====
// Checker for the profile slope smoother: rebuilds the windowed, clamped means
// from accepted requests and register writes, and compares each accepted result.
// Depends on psm_pkg.
module slope_smoother_checker
    import psm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  psm_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  psm_out_t              m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    expected_left,
    output int                    results_checked
);

    localparam logic [WIN_W-1:0]  WIN_RESET   = WIN_W'(3);
    localparam logic [MAXS_W-1:0] CLAMP_RESET = '1;
    localparam int                REPORT_MAX  = 10;

    // Predictor copy of the registers and the profile state
    logic [WIN_W-1:0]               win_reg;
    logic [MAXS_W-1:0]              clamp_reg;
    logic signed [SAMPLE_WIDTH-1:0] slope_hist [HIST_DEPTH];
    logic [HIST_AW-1:0]             hist_wr;
    logic [SEEN_W-1:0]              seen_cnt;
    logic [PEND_W-1:0]              pend_cnt;

    psm_out_t expected_slopes [$];
    psm_out_t want;
    int       bad_results;
    int       checked;

    // Store one sample and queue every mean whose window is now complete
    task automatic predict_smoothing(input psm_in_t smp);
        int       w;
        int       half;
        int       right;
        int       d;
        int       sum;
        int       used;
        int       mean_v;
        int       lim;
        int       seen_i;
        psm_out_t r;
        w = (win_reg == '0) ? 1 : int'(win_reg);
        if (w > MAX_WINDOW) w = MAX_WINDOW;
        half  = w / 2;
        right = w - half - 1;
        slope_hist[hist_wr] = smp.slope_sample;
        hist_wr = hist_wr + 1'b1;
        if (seen_cnt != SEEN_MAX) seen_cnt = seen_cnt + 1'b1;
        if (pend_cnt != PEND_MAX) pend_cnt = pend_cnt + 1'b1;
        seen_i = int'(seen_cnt);
        lim    = int'(clamp_reg);
        // answer positions oldest first; a last sample flushes them all
        while (pend_cnt != '0 && (smp.last_sample || int'(pend_cnt) > right)) begin
            d    = int'(pend_cnt) - 1;
            sum  = 0;
            used = 0;
            // skip offsets outside the profile so the window shrinks at the edges
            for (int off = d - right; off <= d + half; off++) begin
                if (off >= 0 && off < seen_i && off < HIST_DEPTH) begin
                    sum += slope_hist[(int'(hist_wr) - 1 - off) & (HIST_DEPTH - 1)];
                    used++;
                end
            end
            mean_v = (used == 0) ? 0 : sum / used;
            if (mean_v > lim) mean_v = lim;
            else if (mean_v < -lim) mean_v = -lim;
            r.smoothed_slope = SAMPLE_WIDTH'(mean_v);
            r.last_result    = smp.last_sample && (d == 0);
            expected_slopes.push_back(r);
            pend_cnt = pend_cnt - 1'b1;
        end
        if (smp.last_sample) begin
            seen_cnt = '0;
            pend_cnt = '0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   = WIN_RESET;
            clamp_reg = CLAMP_RESET;
            hist_wr   = '0;
            seen_cnt  = '0;
            pend_cnt  = '0;
            expected_slopes.delete();
        end else begin
            // apply register writes; unknown indexes are dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WINDOW_SIZE: win_reg = cfg_data[WIN_W-1:0];
                    CFG_MAX_SLOPE:   clamp_reg = cfg_data[MAXS_W-1:0];
                    default: ;
                endcase
            end
            // compare each accepted result with the oldest expectation
            if (m_valid && m_ready) begin
                if (expected_slopes.size() == 0) begin
                    if (bad_results < REPORT_MAX) begin
                        $display("result %0d: unexpected, got slope %0d last %0b",
                                 checked, m_data.smoothed_slope, m_data.last_result);
                    end
                    bad_results++;
                end else begin
                    want = expected_slopes.pop_front();
                    if (m_data.smoothed_slope !== want.smoothed_slope ||
                        m_data.last_result !== want.last_result) begin
                        if (bad_results < REPORT_MAX) begin
                            $display("result %0d: expected slope %0d last %0b, got slope %0d last %0b",
                                     checked, want.smoothed_slope, want.last_result,
                                     m_data.smoothed_slope, m_data.last_result);
                        end
                        bad_results++;
                    end
                end
                checked++;
            end
            if (s_valid && s_ready) predict_smoothing(s_data);
        end
        mismatch_count  <= bad_results;
        expected_left   <= expected_slopes.size();
        results_checked <= checked;
    end

endmodule

// ===== tb/tb_profile_slope_smoother.sv =====
// Testbench top for the profile slope smoother: clock, reset, sample and register
// stimulus, random back-pressure and the verdict. Depends on psm_pkg, the
// smoother and slope_smoother_checker.
module tb_profile_slope_smoother;
    import psm_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int RANDOM_SAMPLES = 190;
    localparam int IDLE_PCT       = 7;
    localparam logic [CFG_IDX_W-1:0]           CFG_SPARE_INDEX = CFG_IDX_W'(3);
    localparam logic signed [SAMPLE_WIDTH-1:0] SLOPE_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_WIDTH-1:0] SLOPE_MAX = 16'sh7FFF;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    psm_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    psm_out_t              m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic calm = 1'b0;
    int   cycle_count;
    int   samples_sent;
    int   profiles_sent;
    int   reg_writes;
    int   mismatch_count;
    int   expected_left;
    int   results_checked;

    profile_slope_smoother DUT (.*);

    slope_smoother_checker CHECKER (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Roll for an idle cycle, except during the calm stretch
    function automatic bit take_break();
        return !calm && ($urandom_range(99) < IDLE_PCT);
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_slope();
        case ($urandom_range(9))
            0: return SLOPE_MIN;
            1: return SLOPE_MAX;
            2, 3: return SAMPLE_WIDTH'(int'($urandom_range(400)) - 200);
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    // Offer one sample request and hold it until accepted
    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] slope, input logic last);
        while (take_break()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {slope, last};
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
        if (last) profiles_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge aclk);
    endtask

    // Stop offering samples, wait for every expected result, then let the block settle
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= !take_break();
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int                    random_sent;
        int                    len;
        int                    split;
        logic [CFG_DATA_W-1:0] win_data;
        logic [CFG_DATA_W-1:0] lim_data;
        random_sent = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: a one-sample profile, then full-scale extremes
        send_sample(SLOPE_MAX, 1'b1);
        send_sample(SLOPE_MIN, 1'b0);
        send_sample(SLOPE_MIN, 1'b0);
        send_sample(SLOPE_MAX, 1'b0);
        send_sample('0, 1'b1);
        drain_results();

        // zero window acts as one; clamp both signs
        write_reg(CFG_WINDOW_SIZE, '0);
        write_reg(CFG_MAX_SLOPE, CFG_DATA_W'(100));
        send_sample(16'sd5000, 1'b0);
        send_sample(-16'sd5000, 1'b0);
        send_sample(16'sd50, 1'b1);
        drain_results();

        // even window reaches one sample less to the right
        write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(4));
        write_reg(CFG_MAX_SLOPE, '1);
        for (int i = 0; i < 5; i++) send_sample(pick_slope(), i == 4);
        drain_results();

        // widest window, zero limit, then shrink mid-profile to flush a backlog
        write_reg(CFG_SPARE_INDEX, '1);
        write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(31));
        write_reg(CFG_MAX_SLOPE, '0);
        for (int i = 0; i < 10; i++) send_sample(pick_slope(), 1'b0);
        drain_results();
        write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(3));
        write_reg(CFG_MAX_SLOPE, CFG_DATA_W'(16'h7FFF));
        send_sample(pick_slope(), 1'b0);
        send_sample(pick_slope(), 1'b1);
        drain_results();

        // random profiles under changing settings
        while (random_sent < RANDOM_SAMPLES) begin
            calm <= (random_sent >= 90 && random_sent < 150);
            if ($urandom_range(9) < 7) begin
                drain_results();
                win_data = CFG_DATA_W'($urandom);
                case ($urandom_range(5))
                    0: win_data[WIN_W-1:0] = '0;
                    1: win_data[WIN_W-1:0] = '1;
                    2: win_data[WIN_W-1:0] = WIN_W'(1);
                    3: win_data[WIN_W-1:0] = WIN_W'(2 * $urandom_range(1, 3) + 1);
                    default: ;
                endcase
                lim_data = CFG_DATA_W'($urandom);
                case ($urandom_range(5))
                    0: lim_data[MAXS_W-1:0] = '0;
                    1: lim_data[MAXS_W-1:0] = '1;
                    2: lim_data[MAXS_W-1:0] = MAXS_W'($urandom_range(1, 2000));
                    default: ;
                endcase
                write_reg(CFG_WINDOW_SIZE, win_data);
                write_reg(CFG_MAX_SLOPE, lim_data);
                if ($urandom_range(7) == 0) write_reg(CFG_SPARE_INDEX, CFG_DATA_W'($urandom));
            end
            case ($urandom_range(9))
                0: len = 1;
                7, 8: len = $urandom_range(13, 40);
                9: len = $urandom_range(41, 70);
                default: len = $urandom_range(2, 12);
            endcase
            split = ($urandom_range(6) == 0) ? $urandom_range(1, len) : -1;
            for (int i = 0; i < len; i++) begin
                // change the window between two samples of one profile
                if (i == split) begin
                    drain_results();
                    write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'($urandom));
                end
                send_sample(pick_slope(), i == len - 1);
                random_sent++;
            end
        end
        drain_results();

        $display("run covered %0d samples in %0d profiles with %0d register writes",
                 samples_sent, profiles_sent, reg_writes);
        $display("%0d smoothed results checked in %0d cycles", results_checked, cycle_count);
        if (mismatch_count == 0 && expected_left == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
